// File: rtl/hfd_pkg.sv
package hfd_pkg;

  localparam logic [7:0] ChrCr    = 8'h0d;
  localparam logic [7:0] ChrLf    = 8'h0a;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrF     = 8'h46;
  localparam logic [7:0] ChrL     = 8'h4c;
  localparam logic [7:0] ChrV     = 8'h56;

  localparam logic [2:0] AddrHdrSize = 3'd0;  // expected FLV header size register

  localparam logic [3:0] FlvHdrLast = 4'd12;  // 13-byte FLV header
  localparam logic [3:0] TagHdrLast = 4'd10;  // 11-byte tag header
  localparam logic [24:0] TrailerBytes = 25'd4;
  localparam logic [24:0] TagOverhead  = 25'd15;

  typedef enum logic [1:0] {
    EvHeadersDone = 2'd0,
    EvTag         = 2'd1,
    EvBadStatus   = 2'd2,
    EvBadFlv      = 2'd3
  } event_e;

  typedef enum logic [5:0] {
    PhStatus  = 6'b000001,
    PhHeaders = 6'b000010,
    PhFlvHdr  = 6'b000100,
    PhTagHdr  = 6'b001000,
    PhTagData = 6'b010000,
    PhFailed  = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [1:0] tok_idx;
    logic [2:0] char_pos;
    logic       line_ok;
  } line_st_t;

  typedef struct packed {
    logic [24:0] whole_size;
    logic [23:0] payload_size;
    logic [7:0]  tag_kind;
    logic [1:0]  event_res;
  } result_t;

  function automatic logic [7:0] proto_chr(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h48;  // H
      3'd1:    c = 8'h54;  // T
      3'd2:    c = 8'h54;  // T
      3'd3:    c = 8'h50;  // P
      default: c = 8'h2f;  // slash
    endcase
    return c;
  endfunction

  function automatic logic [7:0] code_chr(input logic [2:0] idx);
    return (idx == 3'd0) ? 8'h32 : 8'h30;  // "200"
  endfunction

  function automatic logic [7:0] reason_chr(input logic [2:0] idx);
    return (idx == 3'd0) ? 8'h4f : 8'h4b;  // "OK"
  endfunction

  function automatic logic [7:0] blank_chr(input logic [1:0] idx);
    return idx[0] ? ChrLf : ChrCr;
  endfunction

  // Advance the status-line token checker by one content character.
  function automatic line_st_t line_char(input line_st_t st, input logic [7:0] c);
    line_st_t r;
    logic     done;
    r = st;
    if (c == ChrSpace) begin
      if (st.tok_idx == 2'd0) begin
        done = st.char_pos >= 3'd5;
      end else if (st.tok_idx == 2'd1) begin
        done = st.char_pos == 3'd3;
      end else begin
        done = 1'b0;
      end
      if (!done) r.line_ok = 1'b0;
      if (st.tok_idx < 2'd2) r.tok_idx = st.tok_idx + 2'd1;
      r.char_pos = 3'd0;
    end else if (st.tok_idx == 2'd0) begin
      if (st.char_pos < 3'd5) begin
        if (c != proto_chr(st.char_pos)) r.line_ok = 1'b0;
        r.char_pos = st.char_pos + 3'd1;
      end
    end else if (st.tok_idx == 2'd1) begin
      if (st.char_pos < 3'd3 && c == code_chr(st.char_pos)) begin
        r.char_pos = st.char_pos + 3'd1;
      end else begin
        r.line_ok = 1'b0;
      end
    end else begin
      if (st.char_pos < 3'd2 && c == reason_chr(st.char_pos)) begin
        r.char_pos = st.char_pos + 3'd1;
      end else begin
        r.line_ok = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/http_flv_stream_deframer_unit.sv
// HTTP-FLV deframer: takes one response byte per beat, validates the status line
// ("HTTP/..." "200" "OK"), skips headers to the blank line, checks the 13-byte FLV
// header against expected_header_size (APB offset 0, reset 9) and then reports each
// tag header. While the output is not stalled, one byte is taken every clock; a byte
// passes an input register, then the parser logic loads the result register. The
// parser state updates as the result register loads, which sets the one-byte-per-clock
// rate. After any error event the block stays silent until reset.
module http_flv_stream_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [1:0] event_res, [9:2] tag_kind,
                                      // [33:10] payload_size, [58:34] whole_size
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             in_valid_q, in_valid_d;
  logic [7:0]       in_byte_q, in_byte_d;
  logic             out_valid_q, out_valid_d;
  hfd_pkg::result_t out_q, out_d;
  logic             advance, step, res_valid;
  logic [31:0]      exp_size;
  hfd_pkg::result_t res;

  hfd_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .exp_size_o(exp_size)
  );

  hfd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .exp_size_i (exp_size),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d  = in_valid_q;
    in_byte_d   = in_byte_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
      in_byte_d  = s_axis_tdata;
    end
    if (advance) begin
      out_valid_d = step && res_valid;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    out_q     <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.whole_size, out_q.payload_size,
                          out_q.tag_kind, out_q.event_res};

endmodule

// File: rtl/hfd_regs.sv
module hfd_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] exp_size_o
);

  logic [31:0] exp_size_q, exp_size_d;
  logic        wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr == hfd_pkg::AddrHdrSize);

  always_comb begin
    exp_size_d = exp_size_q;
    if (wr_hit) exp_size_d = pwdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_size_q <= 32'd9;
    end else begin
      exp_size_q <= exp_size_d;
    end
  end

  assign prdata     = (paddr == hfd_pkg::AddrHdrSize) ? exp_size_q : 32'd0;
  assign exp_size_o = exp_size_q;

endmodule

// File: rtl/hfd_parser.sv
module hfd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  logic [31:0]          exp_size_i,
  output logic                 res_valid_o,
  output hfd_pkg::result_t     res_o
);

  hfd_pkg::phase_e   phase_q, phase_d;
  hfd_pkg::line_st_t line_q, line_d;
  logic              cr_pend_q, cr_pend_d;
  logic [1:0]        blank_q, blank_d;
  logic [3:0]        hcnt_q, hcnt_d;
  logic              sig_ok_q, sig_ok_d;
  logic [31:0]       size_word_q, size_word_d;
  logic [7:0]        kind_q, kind_d;
  logic [24:0]       skip_q, skip_d;

  hfd_pkg::line_st_t line_mid;

  always_comb begin
    phase_d     = phase_q;
    line_d      = line_q;
    cr_pend_d   = cr_pend_q;
    blank_d     = blank_q;
    hcnt_d      = hcnt_q;
    sig_ok_d    = sig_ok_q;
    size_word_d = size_word_q;
    kind_d      = kind_q;
    skip_d      = skip_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    line_mid    = cr_pend_q ? hfd_pkg::line_char(line_q, hfd_pkg::ChrCr) : line_q;

    unique case (phase_q)
      hfd_pkg::PhStatus: begin
        if (cr_pend_q && byte_i == hfd_pkg::ChrLf) begin
          cr_pend_d = 1'b0;
          if (line_q.line_ok && line_q.tok_idx == 2'd2 && line_q.char_pos == 3'd2) begin
            phase_d = hfd_pkg::PhHeaders;
            blank_d = 2'd0;
          end else begin
            phase_d         = hfd_pkg::PhFailed;
            res_valid_o     = 1'b1;
            res_o.event_res = hfd_pkg::EvBadStatus;
          end
        end else if (byte_i == hfd_pkg::ChrCr) begin
          // hold the CR until the next byte decides whether it ends the line
          cr_pend_d = 1'b1;
          line_d    = line_mid;
        end else begin
          cr_pend_d = 1'b0;
          line_d    = hfd_pkg::line_char(line_mid, byte_i);
        end
      end

      hfd_pkg::PhHeaders: begin
        if (byte_i == hfd_pkg::blank_chr(blank_q)) begin
          if (blank_q == 2'd3) begin
            blank_d         = 2'd0;
            phase_d         = hfd_pkg::PhFlvHdr;
            hcnt_d          = 4'd0;
            sig_ok_d        = 1'b1;
            size_word_d     = 32'd0;
            res_valid_o     = 1'b1;
            res_o.event_res = hfd_pkg::EvHeadersDone;
          end else begin
            blank_d = blank_q + 2'd1;
          end
        end else begin
          blank_d = (byte_i == hfd_pkg::ChrCr) ? 2'd1 : 2'd0;
        end
      end

      hfd_pkg::PhFlvHdr: begin
        if ((hcnt_q == 4'd0 && byte_i != hfd_pkg::ChrF) ||
            (hcnt_q == 4'd1 && byte_i != hfd_pkg::ChrL) ||
            (hcnt_q == 4'd2 && byte_i != hfd_pkg::ChrV)) begin
          sig_ok_d = 1'b0;
        end
        if (hcnt_q >= 4'd5 && hcnt_q <= 4'd8) size_word_d = {size_word_q[23:0], byte_i};
        if (hcnt_q != hfd_pkg::FlvHdrLast) begin
          hcnt_d = hcnt_q + 4'd1;
        end else begin
          hcnt_d = 4'd0;
          if (sig_ok_q && size_word_q == exp_size_i) begin
            phase_d = hfd_pkg::PhTagHdr;
            skip_d  = 25'd0;
          end else begin
            phase_d         = hfd_pkg::PhFailed;
            res_valid_o     = 1'b1;
            res_o.event_res = hfd_pkg::EvBadFlv;
          end
        end
      end

      hfd_pkg::PhTagHdr: begin
        if (hcnt_q == 4'd0) begin
          kind_d = byte_i;
          skip_d = 25'd0;
        end else if (hcnt_q <= 4'd3) begin
          skip_d = {1'b0, skip_q[15:0], byte_i};
        end
        if (hcnt_q != hfd_pkg::TagHdrLast) begin
          hcnt_d = hcnt_q + 4'd1;
        end else begin
          hcnt_d             = 4'd0;
          res_valid_o        = 1'b1;
          res_o.event_res    = hfd_pkg::EvTag;
          res_o.tag_kind     = kind_q;
          res_o.payload_size = skip_q[23:0];
          res_o.whole_size   = {1'b0, skip_q[23:0]} + hfd_pkg::TagOverhead;
          skip_d             = {1'b0, skip_q[23:0]} + hfd_pkg::TrailerBytes;
          phase_d            = hfd_pkg::PhTagData;
        end
      end

      hfd_pkg::PhTagData: begin
        if (skip_q != 25'd0) skip_d = skip_q - 25'd1;
        if (skip_q <= 25'd1) phase_d = hfd_pkg::PhTagHdr;
      end

      default: begin
        // failed: drop every byte
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hfd_pkg::PhStatus;
      line_q      <= '{tok_idx: 2'd0, char_pos: 3'd0, line_ok: 1'b1};
      cr_pend_q   <= 1'b0;
      blank_q     <= 2'd0;
      hcnt_q      <= 4'd0;
      sig_ok_q    <= 1'b1;
      size_word_q <= 32'd0;
      kind_q      <= 8'd0;
      skip_q      <= 25'd0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      line_q      <= line_d;
      cr_pend_q   <= cr_pend_d;
      blank_q     <= blank_d;
      hcnt_q      <= hcnt_d;
      sig_ok_q    <= sig_ok_d;
      size_word_q <= size_word_d;
      kind_q      <= kind_d;
      skip_q      <= skip_d;
    end
  end

endmodule

// File: bench/http_flv_stream_deframer_unit_tb.sv
`timescale 1ns / 1ps

module http_flv_stream_deframer_unit_tb;

  localparam int RandItems  = 750;
  localparam int MinTags    = 12;
  localparam int HoldCycles = 300;

  localparam logic [39:0] ProtoTxt  = "HTTP/";
  localparam logic [23:0] CodeTxt   = "200";
  localparam logic [15:0] ReasonTxt = "OK";

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  http_flv_stream_deframer_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Parser mirror: state and register copy.
  hfd_pkg::phase_e flv_ph   = hfd_pkg::PhStatus;
  logic [1:0]  tok          = 2'd0;
  logic [2:0]  cpos         = 3'd0;
  bit          line_ok      = 1'b1;
  bit          cr_seen      = 1'b0;
  logic [1:0]  blank_cnt    = 2'd0;
  logic [3:0]  hdr_cnt      = 4'd0;
  bit          sig_ok       = 1'b1;
  logic [31:0] size_acc     = 32'd0;
  logic [7:0]  kind_q       = 8'd0;
  logic [24:0] skip_cnt     = 25'd0;
  logic [31:0] hdr_size_cfg = 32'd9;

  hfd_pkg::result_t pending_events [$];
  int      fail_cnt     = 0;
  int      bytes_sent   = 0;
  int      tags_sent    = 0;
  int      events_seen  = 0;
  int      snd_idle_pct = 19;
  int      rcv_idle_pct = 83;
  int      stall_left   = 0;
  bit      stall_done   = 1'b0;

  typedef struct packed {
    logic [7:0]       b;
    logic             typed;
    hfd_pkg::result_t res;
  } dir_row_t;

  // Minimal status line with odd bytes and a lone CR after the prefix, then a
  // header line and a broken blank-line match before the real CR LF CR LF.
  dir_row_t dir_tab [25] = '{
    '{8'h48, 1'b0, '0}, '{8'h54, 1'b0, '0}, '{8'h54, 1'b0, '0},
    '{8'h50, 1'b0, '0}, '{8'h2f, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'hff, 1'b0, '0}, '{hfd_pkg::ChrCr, 1'b0, '0},
    '{hfd_pkg::ChrSpace, 1'b0, '0},
    '{8'h32, 1'b0, '0}, '{8'h30, 1'b0, '0}, '{8'h30, 1'b0, '0},
    '{hfd_pkg::ChrSpace, 1'b0, '0},
    '{8'h4f, 1'b0, '0}, '{8'h4b, 1'b0, '0},
    '{hfd_pkg::ChrCr, 1'b0, '0}, '{hfd_pkg::ChrLf, 1'b0, '0},
    '{8'h41, 1'b0, '0}, '{hfd_pkg::ChrCr, 1'b0, '0}, '{hfd_pkg::ChrLf, 1'b0, '0},
    '{hfd_pkg::ChrCr, 1'b0, '0}, '{hfd_pkg::ChrCr, 1'b0, '0},
    '{hfd_pkg::ChrLf, 1'b0, '0},
    '{hfd_pkg::ChrCr, 1'b0, '0},
    '{hfd_pkg::ChrLf, 1'b1, '{25'd0, 24'd0, 8'd0, hfd_pkg::EvHeadersDone}}
  };

  task automatic flag_error(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", msg);
  endtask

  task automatic status_char(input logic [7:0] c);
    bit done;
    int k;
    k = cpos;
    if (c == hfd_pkg::ChrSpace) begin
      if (tok == 2'd0) begin
        done = (cpos >= 3'd5);
      end else if (tok == 2'd1) begin
        done = (cpos == 3'd3);
      end else begin
        done = 1'b0;
      end
      if (!done) line_ok = 1'b0;
      if (tok < 2'd2) tok = tok + 2'd1;
      cpos = 3'd0;
    end else if (tok == 2'd0) begin
      if (cpos < 3'd5) begin
        if (c != ProtoTxt[8*(4-k) +: 8]) line_ok = 1'b0;
        cpos = cpos + 3'd1;
      end
    end else if (tok == 2'd1) begin
      if (cpos < 3'd3 && c == CodeTxt[8*(2-k) +: 8]) cpos = cpos + 3'd1;
      else line_ok = 1'b0;
    end else begin
      if (cpos < 3'd2 && c == ReasonTxt[8*(1-k) +: 8]) cpos = cpos + 3'd1;
      else line_ok = 1'b0;
    end
  endtask

  task automatic flv_parse_byte(input logic [7:0] b, output bit hit,
                                output hfd_pkg::result_t r);
    hit = 1'b0;
    r = '0;
    case (flv_ph)
      hfd_pkg::PhStatus: begin
        if (cr_seen && b == hfd_pkg::ChrLf) begin
          cr_seen = 1'b0;
          if (line_ok && tok == 2'd2 && cpos == 3'd2) begin
            flv_ph = hfd_pkg::PhHeaders;
            blank_cnt = 2'd0;
          end else begin
            flv_ph = hfd_pkg::PhFailed;
            hit = 1'b1;
            r.event_res = hfd_pkg::EvBadStatus;
          end
        end else begin
          // an unmatched CR counts as a line character
          if (cr_seen) status_char(hfd_pkg::ChrCr);
          if (b == hfd_pkg::ChrCr) begin
            cr_seen = 1'b1;
          end else begin
            cr_seen = 1'b0;
            status_char(b);
          end
        end
      end
      hfd_pkg::PhHeaders: begin
        if (b == (blank_cnt[0] ? hfd_pkg::ChrLf : hfd_pkg::ChrCr)) begin
          if (blank_cnt == 2'd3) begin
            blank_cnt = 2'd0;
            flv_ph = hfd_pkg::PhFlvHdr;
            hdr_cnt = 4'd0;
            sig_ok = 1'b1;
            size_acc = 32'd0;
            hit = 1'b1;
            r.event_res = hfd_pkg::EvHeadersDone;
          end else begin
            blank_cnt = blank_cnt + 2'd1;
          end
        end else begin
          blank_cnt = (b == hfd_pkg::ChrCr) ? 2'd1 : 2'd0;
        end
      end
      hfd_pkg::PhFlvHdr: begin
        if (hdr_cnt == 4'd0 && b != hfd_pkg::ChrF) sig_ok = 1'b0;
        if (hdr_cnt == 4'd1 && b != hfd_pkg::ChrL) sig_ok = 1'b0;
        if (hdr_cnt == 4'd2 && b != hfd_pkg::ChrV) sig_ok = 1'b0;
        if (hdr_cnt >= 4'd5 && hdr_cnt <= 4'd8) size_acc = {size_acc[23:0], b};
        if (hdr_cnt != hfd_pkg::FlvHdrLast) begin
          hdr_cnt = hdr_cnt + 4'd1;
        end else begin
          hdr_cnt = 4'd0;
          if (sig_ok && size_acc == hdr_size_cfg) begin
            flv_ph = hfd_pkg::PhTagHdr;
            skip_cnt = 25'd0;
          end else begin
            flv_ph = hfd_pkg::PhFailed;
            hit = 1'b1;
            r.event_res = hfd_pkg::EvBadFlv;
          end
        end
      end
      hfd_pkg::PhTagHdr: begin
        if (hdr_cnt == 4'd0) begin
          kind_q = b;
          skip_cnt = 25'd0;
        end else if (hdr_cnt <= 4'd3) begin
          skip_cnt = {1'b0, skip_cnt[15:0], b};
        end
        if (hdr_cnt != hfd_pkg::TagHdrLast) begin
          hdr_cnt = hdr_cnt + 4'd1;
        end else begin
          hdr_cnt = 4'd0;
          hit = 1'b1;
          r.event_res = hfd_pkg::EvTag;
          r.tag_kind = kind_q;
          r.payload_size = skip_cnt[23:0];
          r.whole_size = skip_cnt + hfd_pkg::TagOverhead;
          skip_cnt = skip_cnt + hfd_pkg::TrailerBytes;
          flv_ph = hfd_pkg::PhTagData;
        end
      end
      hfd_pkg::PhTagData: begin
        if (skip_cnt != 25'd0) skip_cnt = skip_cnt - 25'd1;
        if (skip_cnt == 25'd0) flv_ph = hfd_pkg::PhTagHdr;
      end
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input hfd_pkg::result_t typed_res = '0);
    bit               hit;
    hfd_pkg::result_t pred;
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    flv_parse_byte(b, hit, pred);
    if (typed) pending_events.insert(pending_events.size(), typed_res);
    else if (hit) pending_events.insert(pending_events.size(), pred);
    bytes_sent++;
    if (bytes_sent == RandItems / 3) begin
      snd_idle_pct = 83;
      rcv_idle_pct = 19;
    end else if (bytes_sent == 2 * RandItems / 3) begin
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
    end
  endtask

  task automatic send_tag(input logic [7:0] kind, input logic [23:0] tag_len,
                          input int body_len);
    send_byte(kind);
    send_byte(tag_len[23:16]);
    send_byte(tag_len[15:8]);
    send_byte(tag_len[7:0]);
    repeat (7) send_byte(8'($urandom_range(255)));
    tags_sent++;
    repeat (body_len) send_byte(8'($urandom_range(255)));
  endtask

  // Drop valid, wait for every outstanding result, then cover the pipeline.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= hfd_pkg::AddrHdrSize;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    hdr_size_cfg = v;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== v) flag_error($sformatf("readback: expected %h, got %h", v, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && events_seen >= 1) begin
      // hold off long enough for results to back up into the input
      m_axis_tready <= 1'b0;
      stall_left <= HoldCycles;
      stall_done <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    hfd_pkg::result_t got;
    hfd_pkg::result_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      got = m_axis_tdata[58:0];
      events_seen <= events_seen + 1;
      if (pending_events.size() == 0) begin
        flag_error($sformatf("unexpected result: ev=%0d kind=%0d size=%0d whole=%0d",
                             got.event_res, got.tag_kind, got.payload_size,
                             got.whole_size));
      end else begin
        want = pending_events.pop_front();
        if (got.event_res !== want.event_res || got.tag_kind !== want.tag_kind ||
            got.payload_size !== want.payload_size ||
            got.whole_size !== want.whole_size || m_axis_tdata[63:59] !== 5'd0) begin
          flag_error($sformatf(
              "mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d pad=%h",
              want.event_res, want.tag_kind, want.payload_size, want.whole_size,
              got.event_res, got.tag_kind, got.payload_size, got.whole_size,
              m_axis_tdata[63:59]));
        end
      end
    end
  end

  initial begin
    logic [31:0] hdr_size;
    logic [7:0]  flv_hdr [13];
    bit          flv_broken;
    int          idx;
    int          pick;
    int          cfg_writes;
    logic [7:0]  kind;
    logic [23:0] tag_len;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = hfd_pkg::AddrHdrSize;
    pwdata        = 32'd0;
    cfg_writes    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    cfg_write(32'h0000_0000);

    foreach (dir_tab[i]) send_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].res);

    case ($urandom_range(3))
      0:       hdr_size = 32'd9;
      1:       hdr_size = 32'hffff_ffff;
      2:       hdr_size = 32'd0;
      default: hdr_size = $urandom;
    endcase
    flv_broken = ($urandom_range(7) == 0);
    flv_hdr[0] = hfd_pkg::ChrF;
    flv_hdr[1] = hfd_pkg::ChrL;
    flv_hdr[2] = hfd_pkg::ChrV;
    flv_hdr[3] = 8'($urandom_range(255));
    flv_hdr[4] = 8'($urandom_range(255));
    flv_hdr[5] = hdr_size[31:24];
    flv_hdr[6] = hdr_size[23:16];
    flv_hdr[7] = hdr_size[15:8];
    flv_hdr[8] = hdr_size[7:0];
    for (int i = 9; i < 13; i++) flv_hdr[i] = 8'($urandom_range(255));
    if (flv_broken) begin
      idx = $urandom_range(1) ? $urandom_range(2) : 5 + $urandom_range(3);
      flv_hdr[idx] = flv_hdr[idx] ^ (8'h01 << $urandom_range(7));
    end

    // Wrong size first; the right one lands mid-header, before the comparison.
    settle();
    cfg_write(~hdr_size);
    for (int i = 0; i < 13; i++) begin
      if (i == 6) begin
        settle();
        cfg_write(hdr_size);
      end
      send_byte(flv_hdr[i]);
    end

    if (flv_broken) begin
      // failed parser: everything after is ignored
      while (bytes_sent < RandItems) send_byte(8'($urandom_range(255)));
      settle();
      cfg_write(32'hffff_ffff);
    end else begin
      while (bytes_sent < RandItems || tags_sent < MinTags) begin
        pick = $urandom_range(9);
        if (pick < 3) kind = 8'd8;
        else if (pick < 6) kind = 8'd9;
        else if (pick < 7) kind = 8'd18;
        else kind = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 85) tag_len = 24'($urandom_range(12));
        else if (pick < 97) tag_len = 24'($urandom_range(100, 13));
        else tag_len = 24'($urandom_range(600, 101));
        send_tag(kind, tag_len, tag_len + 4);
        if (tags_sent % 12 == 0) begin
          settle();
          case (cfg_writes % 3)
            0:       cfg_write(32'hffff_ffff);
            1:       cfg_write(32'h0000_0000);
            default: cfg_write($urandom);
          endcase
          cfg_writes++;
        end
      end
      // largest tag last; its data is never walked to the end
      send_tag(8'hff, 24'hff_ffff, 6);
    end

    settle();
    if (fail_cnt == 0 && pending_events.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/hfd_pkg.sv
rtl/hfd_regs.sv
rtl/hfd_parser.sv
rtl/http_flv_stream_deframer_unit.sv
bench/http_flv_stream_deframer_unit_tb.sv
